// File: sv/ise_pkg.sv
`default_nettype none

package ise_pkg;

    localparam int VALUE_W = 32;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the incoming word, shift larger entries up
        logic pop;      // hand every entry one cell toward the output
    } ise_cmd_t;

endpackage

`default_nettype wire

// File: sv/ise_cell.sv
`default_nettype none

module ise_cell
    import ise_pkg::*;
(
    input  wire logic               aclk,
    input  wire ise_cmd_t           cmd,
    input  wire logic [VALUE_W-1:0] new_value,
    input  wire logic               empty,
    input  wire logic               left_gt,
    input  wire logic [VALUE_W-1:0] left_value,
    input  wire logic [VALUE_W-1:0] right_value,
    output logic [VALUE_W-1:0]      value,
    output logic                    gt
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    // strict compare keeps equal words in arrival order
    assign gt    = empty || ($signed(value_reg) > $signed(new_value));
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        priority if (cmd.insert && gt) begin
            value_next = left_gt ? left_value : new_value;
        end else if (cmd.pop) begin
            value_next = right_value;
        end else begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// File: sv/ise_ctrl.sv
`default_nettype none

module ise_ctrl
    import ise_pkg::*;
#(
    parameter int MAX_ITEMS = 16,
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tlast,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic              m_tlast,
    output logic              m_dropped,
    output ise_cmd_t          cmd,
    output logic [CNT_W-1:0]  count
);

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  remaining_reg, remaining_next;
    logic              overflow_reg, overflow_next;
    logic              dropped_reg, dropped_next;
    logic              full;
    logic              accept;

    assign full      = (count_reg == CNT_W'(MAX_ITEMS));
    assign s_tready  = (state_reg == ST_FILL);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_DRAIN);
    assign m_tlast   = (remaining_reg == CNT_W'(1));
    assign m_dropped = dropped_reg;
    assign count     = count_reg;

    assign cmd.insert = accept && !full;
    assign cmd.pop    = m_tvalid && m_tready;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        overflow_next  = overflow_reg;
        dropped_next   = dropped_reg;
        unique case (state_reg)
            ST_FILL: begin
                if (accept) begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        state_next     = ST_DRAIN;
                        remaining_next = full ? count_reg : count_reg + CNT_W'(1);
                        dropped_next   = overflow_reg || full;
                        count_next     = '0;
                        overflow_next  = 1'b0;
                    end
                end
            end
            ST_DRAIN: begin
                if (cmd.pop) begin
                    remaining_next = remaining_reg - CNT_W'(1);
                    if (remaining_reg == CNT_W'(1)) begin
                        state_next = ST_FILL;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            count_reg     <= '0;
            remaining_reg <= '0;
            overflow_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            overflow_reg  <= overflow_next;
            dropped_reg   <= dropped_next;
        end
    end

    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (remaining_reg != '0))
        else $error("drain with no words left");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_close_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (state_reg == ST_DRAIN) && (count_reg == '0))
        else $error("closing word did not start drain");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (overflow_reg && state_reg == ST_FILL) |-> full)
        else $error("overflow flagged while chain not full");

endmodule

`default_nettype wire

// File: sv/insertion_sort_engine.sv
// Fill: one word accepted per cycle; each is placed in the cell chain in that cycle unless it is full.
// Close: after the word with s_tlast, the first sorted word is valid the next cycle,
// then one word per cycle while m_tready is high.
// s_tready is low during drain, so the next list waits until its last sorted word is taken.
// Reset (aresetn low, synchronous) clears fill count, overflow flag and drain state;
// cell contents are not reset.
`default_nettype none

module insertion_sort_engine
    import ise_pkg::*;
#(
    parameter int MAX_ITEMS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] item_value
    input  wire logic        s_tlast,   // item_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] sorted_value
    output logic             m_tlast,   // sorted_last
    output logic [0:0]       m_tuser    // [0] dropped
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    ise_cmd_t            cmd;
    logic [CNT_W-1:0]    count;
    logic                dropped;
    logic [VALUE_W-1:0]  cell_value [MAX_ITEMS];
    logic                cell_gt    [MAX_ITEMS];

    ise_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .m_dropped (dropped),
        .cmd       (cmd),
        .count     (count)
    );

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic               left_gt;
        logic [VALUE_W-1:0] left_value;
        logic [VALUE_W-1:0] right_value;
        logic               empty;

        assign empty = (CNT_W'(i) >= count);

        if (i == 0) begin : g_head
            assign left_gt    = 1'b0;
            assign left_value = s_tdata;
        end else begin : g_body
            assign left_gt    = cell_gt[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_tail
            assign right_value = cell_value[i];
        end else begin : g_mid
            assign right_value = cell_value[i+1];
        end

        ise_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .new_value   (s_tdata),
            .empty       (empty),
            .left_gt     (left_gt),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .gt          (cell_gt[i])
        );
    end

    // head cell holds the smallest remaining word
    assign m_tdata    = cell_value[0];
    assign m_tuser[0] = dropped;

endmodule

`default_nettype wire

// File: sim/tb_insertion_sort_engine.sv
`timescale 1ns / 1ps

module tb_insertion_sort_engine;
    import ise_pkg::*;

    localparam int SORT_DEPTH  = 16;
    localparam int RANDOM_WORDS = 100;
    localparam int IDLE_PCT    = 31;
    localparam int HOLD_AT     = 30;    // results seen before the long receiver hold-off
    localparam int HOLD_LEN    = 80;
    localparam int DRAIN_WAIT  = 3 * SORT_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
    } sort_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      dropped;
    } sorted_word_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;   // [31:0] item_value
    logic               s_tlast  = 1'b0; // item_last
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;         // [31:0] sorted_value
    logic               m_tlast;         // sorted_last
    logic [0:0]         m_tuser;         // [0] dropped

    insertion_sort_engine #(
        .MAX_ITEMS(SORT_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #1 aclk = ~aclk;

    sort_item_t   unsent_items[$];
    sorted_word_t sorted_expect[$];
    int           total_items   = 0;
    int           words_in      = 0;
    int           results_seen  = 0;
    int           errors        = 0;
    int           lists_closed  = 0;
    int           lists_dropped = 0;
    int           hold_cycles   = 0;
    int           cycle_count   = 0;

    // shadow of the sort chain
    logic signed [VALUE_W-1:0] chain [SORT_DEPTH];
    int                        fill_count = 0;
    logic                      overflow   = 1'b0;

    task automatic sort_insert(input logic signed [VALUE_W-1:0] v, input logic close);
        int           pos;
        sorted_word_t w;
        if (fill_count < SORT_DEPTH) begin
            pos = fill_count;
            // strict compare keeps equal values in arrival order
            while (pos > 0 && chain[pos-1] > v) begin
                chain[pos] = chain[pos-1];
                pos--;
            end
            chain[pos] = v;
            fill_count++;
        end else begin
            overflow = 1'b1;
        end
        if (close) begin
            for (int k = 0; k < fill_count; k++) begin
                w.value   = chain[k];
                w.last    = (k + 1 == fill_count);
                w.dropped = overflow;
                sorted_expect.push_back(w);
            end
            lists_closed++;
            if (overflow)
                lists_dropped++;
            fill_count = 0;
            overflow   = 1'b0;
        end
    endtask

    task automatic add_item(input logic [VALUE_W-1:0] v, input logic close);
        sort_item_t it;
        it.value = v;
        it.last  = close;
        unsent_items.push_back(it);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input int flavor);
        logic [VALUE_W-1:0] v;
        case (flavor)
            0: v = $urandom;
            1: v = $urandom_range(8) - 4;   // crowd the list with duplicates
            default: begin
                case ($urandom_range(5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_0000;
                    3: v = 32'hffff_ffff;
                    4: v = 32'h0000_0001;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // sender
    always @(posedge aclk) begin
        sort_item_t it;
        int         idle_in;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sort_insert(s_tdata, s_tlast);
                words_in <= words_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                idle_in = (words_in >= 60 && words_in < 100) ? 0 : IDLE_PCT;
                if (unsent_items.size() > 0 && $urandom_range(99) >= idle_in) begin
                    it = unsent_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.value;
                    s_tlast  <= it.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, so the input side backs up
    wire holding = (results_seen >= HOLD_AT) && (hold_cycles < HOLD_LEN);

    always @(posedge aclk) begin
        if (aresetn && holding)
            hold_cycles <= hold_cycles + 1;
    end

    // receiver and checker
    always @(posedge aclk) begin
        sorted_word_t exp_w;
        int           idle_out;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (sorted_expect.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected word: value %0d last %0b dropped %0b",
                                 $signed(m_tdata), m_tlast, m_tuser[0]);
                end else begin
                    exp_w = sorted_expect.pop_front();
                    if (m_tdata !== exp_w.value || m_tlast !== exp_w.last
                            || m_tuser[0] !== exp_w.dropped) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"mismatch at word %0d: value %0d/%0d last %0b/%0b",
                                      " dropped %0b/%0b (exp/got)"},
                                     results_seen, exp_w.value, $signed(m_tdata),
                                     exp_w.last, m_tlast, exp_w.dropped, m_tuser[0]);
                    end
                end
            end
            idle_out = (results_seen >= 60 && results_seen < 100) ? 0 : IDLE_PCT;
            m_tready <= !holding && ($urandom_range(99) >= idle_out);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, sorted_expect.size());
            $display("tb_insertion_sort_engine: done, errors");
            $finish;
        end
    end

    initial begin
        int random_count;
        int len;
        int flavor;
        int r;

        // one-word list holding the most negative value
        add_item(32'h8000_0000, 1'b1);
        // extremes in scrambled order
        add_item(32'h7fff_ffff, 1'b0);
        add_item(32'h8000_0000, 1'b0);
        add_item(32'h0000_0000, 1'b0);
        add_item(32'hffff_ffff, 1'b0);
        add_item(32'h0000_0001, 1'b1);
        // equal values around a smaller one
        add_item(32'd7, 1'b0);
        add_item(-32'sd2, 1'b0);
        add_item(32'd7, 1'b1);
        // exactly full list, alternating sign
        for (int i = 0; i < SORT_DEPTH; i++)
            add_item((i % 2) ? -(i * 1000) : i * 1000, i == SORT_DEPTH - 1);

        random_count = 0;
        while (random_count < RANDOM_WORDS) begin
            r = $urandom_range(99);
            if (r < 65)
                len = $urandom_range(8, 1);
            else if (r < 88)
                len = $urandom_range(SORT_DEPTH, 9);
            else
                len = $urandom_range(SORT_DEPTH + 5, SORT_DEPTH + 1);   // overflow
            flavor = $urandom_range(2);
            for (int i = 0; i < len; i++)
                add_item(pick_value(flavor), i == len - 1);
            random_count += len;
        end
        total_items = unsent_items.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_in != total_items)
            @(negedge aclk);
        while (sorted_expect.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("%0d words in %0d lists sorted, %0d lists overflowed,",
                 total_items, lists_closed, lists_dropped);
        $display("%0d sorted words checked", results_seen);
        if (errors == 0 && sorted_expect.size() == 0) begin
            $display("tb_insertion_sort_engine: done, clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_insertion_sort_engine: done, errors");
        end
        $finish;
    end

endmodule
